/* src/drck_pkg.sv */
// shared types, codes and the divider step for the disk request checker
`default_nettype none
package drck_pkg;

  localparam int DIV_STEPS = 32;
  localparam int NSTAGE = 2 * DIV_STEPS;
  localparam logic [8:0] HARD_DISK_BASE = 9'h080;

  localparam logic [2:0] FN_READ_CHS = 3'd0;
  localparam logic [2:0] FN_WRITE_CHS = 3'd1;
  localparam logic [2:0] FN_READ_LBA = 3'd2;
  localparam logic [2:0] FN_WRITE_LBA = 3'd3;
  localparam logic [2:0] FN_LBA_TO_CHS = 3'd4;
  localparam logic [2:0] FN_CHS_TO_LBA = 3'd5;

  localparam logic [2:0] E_NONE = 3'd0;
  localparam logic [2:0] E_INVALID = 3'd1;
  localparam logic [2:0] E_NOT_READY = 3'd2;
  localparam logic [2:0] E_NOT_FOUND = 3'd3;
  localparam logic [2:0] E_PROTECTED = 3'd4;

  localparam logic [2:0] R_HEADS = 3'd0;
  localparam logic [2:0] R_SECTORS = 3'd1;
  localparam logic [2:0] R_IMAGE = 3'd2;
  localparam logic [2:0] R_MEDIUM = 3'd3;
  localparam logic [2:0] R_PROTECT = 3'd4;
  localparam logic [2:0] R_SLOT = 3'd5;

  typedef struct packed {
    logic [7:0]  heads;
    logic [7:0]  sectors;
    logic [22:0] image;
    logic        present;
    logic        protect;
    logic [1:0]  slot;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [2:0]  err;
    logic        is_write;
    logic        chs;
    logic [9:0]  cyl;
    logic [7:0]  head;
    logic [7:0]  sec;
    logic [31:0] addr;
    logic [7:0]  count;
  } req_t;

  typedef struct packed {
    logic        valid;
    logic [2:0]  func;
    logic [2:0]  err;
    logic        is_write;
    logic        chs;
    logic [7:0]  head;
    logic [7:0]  sec;
    logic [7:0]  count;
    logic [31:0] lba;
    logic [26:0] mul;
    logic [31:0] n;
    logic [31:0] q;
    logic [7:0]  r;
    logic [7:0]  srem;
    logic        beyond;
  } stage_t;

  typedef struct packed {
    logic        ok;
    logic [2:0]  error_code;
    logic [31:0] lba_out;
    logic [15:0] cylinder_out;
    logic [7:0]  head_out;
    logic [7:0]  sector_out;
    logic        beyond_image;
  } res_t;

  typedef struct packed {
    logic [7:0]  r;
    logic [31:0] n;
    logic [31:0] q;
  } div_t;

  // one restoring division step, one quotient bit
  function automatic div_t div_step(input logic [7:0] r, input logic [31:0] n,
                                    input logic [31:0] q, input logic [7:0] d);
    logic [8:0] trial;
    div_t res;
    trial = {r, n[31]};
    res.n = {n[30:0], 1'b0};
    if (trial >= {1'b0, d}) begin
      res.r = 8'(trial - {1'b0, d});
      res.q = {q[30:0], 1'b1};
    end else begin
      res.r = trial[7:0];
      res.q = {q[30:0], 1'b0};
    end
    return res;
  endfunction

endpackage
`default_nettype wire

/* src/drck_front.sv */
// front end: drive mapping and early request checks
`default_nettype none
module drck_front #(
  parameter int DRIVE_SLOTS = 4
) (
  input  wire drck_pkg::cfg_t cfg,
  input  wire logic [2:0]  func,
  input  wire logic [7:0]  drive_number,
  input  wire logic [9:0]  cylinder_in,
  input  wire logic [7:0]  head_in,
  input  wire logic [7:0]  sector_in,
  input  wire logic [31:0] block_address,
  input  wire logic [7:0]  sector_count,
  output drck_pkg::req_t   req
);

  logic [8:0] slot;
  logic is_write;
  logic chs;

  always_comb begin
    slot = (drive_number >= drck_pkg::HARD_DISK_BASE[7:0]) ?
           ({1'b0, drive_number} - drck_pkg::HARD_DISK_BASE + 9'd2) : {1'b0, drive_number};
    is_write = (func == drck_pkg::FN_WRITE_CHS) || (func == drck_pkg::FN_WRITE_LBA);
    chs = (func == drck_pkg::FN_READ_CHS) || (func == drck_pkg::FN_WRITE_CHS) ||
          (func == drck_pkg::FN_CHS_TO_LBA);
    req.func = func;
    req.is_write = is_write;
    req.chs = chs;
    req.cyl = cylinder_in;
    req.head = head_in;
    req.sec = sector_in;
    req.addr = block_address;
    req.count = sector_count;
    priority if (func > drck_pkg::FN_CHS_TO_LBA) begin
      req.err = drck_pkg::E_INVALID;
    end else if (slot >= 9'(DRIVE_SLOTS)) begin
      req.err = drck_pkg::E_INVALID;
    end else if (slot != {7'd0, cfg.slot}) begin
      req.err = drck_pkg::E_NOT_READY;
    end else if (func == drck_pkg::FN_LBA_TO_CHS) begin
      req.err = (cfg.heads == 8'd0 || cfg.sectors == 8'd0) ?
                drck_pkg::E_NOT_READY : drck_pkg::E_NONE;
    end else if (func != drck_pkg::FN_CHS_TO_LBA && !cfg.present) begin
      req.err = drck_pkg::E_NOT_READY;
    end else if (is_write && cfg.protect) begin
      req.err = drck_pkg::E_PROTECTED;
    end else if (chs && sector_in == 8'd0) begin
      req.err = drck_pkg::E_NOT_FOUND;
    end else begin
      req.err = drck_pkg::E_NONE;
    end
  end

endmodule
`default_nettype wire

/* src/drck_fifo.sv */
// command queue between front end and back end
`default_nettype none
module drck_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire drck_pkg::req_t  wdata,
  output logic                 full,
  input  wire logic            pop,
  output drck_pkg::req_t       rdata,
  output logic                 empty
);

  drck_pkg::req_t mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic do_push;
  logic do_pop;

  assign full = (count == 3'd4);
  assign empty = (count == 3'd0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count <= 3'd0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 2'd1;
      if (do_pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(do_push) - 3'(do_pop);
    end
  end

endmodule
`default_nettype wire

/* src/drck_back.sv */
// back end: address multiply, range check and pipelined lba to chs divider
`default_nettype none
module drck_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire drck_pkg::cfg_t  cfg,
  input  wire logic            req_valid,
  input  wire drck_pkg::req_t  req,
  output logic                 req_take,
  output logic                 empty,
  input  wire logic            pop,
  output drck_pkg::res_t       res
);

  drck_pkg::stage_t s [drck_pkg::NSTAGE];
  drck_pkg::stage_t head_stage;
  drck_pkg::stage_t last;
  logic en;

  assign last = s[drck_pkg::NSTAGE-1];
  assign en = !last.valid || pop;
  assign req_take = en && req_valid;
  assign empty = !last.valid;

  always_comb begin
    head_stage.valid = req_valid;
    head_stage.func = req.func;
    head_stage.err = req.err;
    head_stage.is_write = req.is_write;
    head_stage.chs = req.chs;
    head_stage.head = req.head;
    head_stage.sec = req.sec;
    head_stage.count = req.count;
    head_stage.lba = req.addr;
    head_stage.mul = {9'd0, {8'd0, req.cyl} * {10'd0, cfg.heads}};
    head_stage.n = req.addr;
    head_stage.q = 32'd0;
    head_stage.r = 8'd0;
    head_stage.srem = 8'd0;
    head_stage.beyond = 1'b0;
  end

  for (genvar k = 0; k < drck_pkg::NSTAGE; k++) begin : g_stage
    drck_pkg::stage_t pv;
    drck_pkg::stage_t nx;
    drck_pkg::div_t dv;
    logic [32:0] span;

    if (k == 0) begin : g_first
      assign pv = head_stage;
    end else begin : g_rest
      assign pv = s[k-1];
    end

    always_comb begin
      nx = pv;
      span = 33'd0;
      if (k == 1) begin
        nx.mul = {8'd0, ({1'b0, pv.mul[17:0]} + {11'd0, pv.head})} * {19'd0, cfg.sectors};
      end
      if (k == 2 && pv.chs) begin
        nx.lba = {5'd0, pv.mul} + {24'd0, pv.sec} - 32'd1;
      end
      if (k == 3) begin
        span = {1'b0, pv.lba} + {25'd0, pv.count};
        if (pv.err == drck_pkg::E_NONE && pv.func != drck_pkg::FN_LBA_TO_CHS &&
            pv.func != drck_pkg::FN_CHS_TO_LBA && span > {10'd0, cfg.image}) begin
          if (pv.is_write) begin
            nx.beyond = 1'b1;
          end else begin
            nx.err = drck_pkg::E_NOT_FOUND;
          end
        end
      end
      if (k == drck_pkg::DIV_STEPS) begin
        nx.srem = pv.r;
        nx.n = pv.q;
        nx.q = 32'd0;
        nx.r = 8'd0;
      end
      dv = drck_pkg::div_step(nx.r, nx.n, nx.q,
                              (k < drck_pkg::DIV_STEPS) ? cfg.sectors : cfg.heads);
      nx.r = dv.r;
      nx.n = dv.n;
      nx.q = dv.q;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        s[k].valid <= 1'b0;
      end else if (en) begin
        s[k] <= nx;
      end
    end
  end

  always_comb begin
    res.ok = (last.err == drck_pkg::E_NONE);
    res.error_code = last.err;
    res.lba_out = res.ok ? last.lba : 32'd0;
    res.beyond_image = res.ok && last.beyond;
    if (res.ok && last.func == drck_pkg::FN_LBA_TO_CHS) begin
      res.cylinder_out = last.q[15:0];
      res.head_out = last.r;
      res.sector_out = last.srem + 8'd1;
    end else begin
      res.cylinder_out = 16'd0;
      res.head_out = 8'd0;
      res.sector_out = 8'd0;
    end
  end

endmodule
`default_nettype wire

/* src/disk_request_chs_lba_checker.sv */
// top level: configuration registers, front end, command queue and back end
//
//   channel   handshake       payload
//   request   push / full     func drive_number cylinder_in head_in sector_in
//                             block_address sector_count
//   result    empty / pop     ok error_code lba_out cylinder_out head_out
//                             sector_out beyond_image
//   config    apb psel/penable/pwrite, pready tied high
//
// one request per cycle sustained while no result stalls; a request passes
// through the queue and then the 64-stage back end, set by the two
// 32-step pipelined divisions
// a stalled result holds the whole back end; the 4-entry queue keeps taking
// requests until full
// rst is synchronous and resets the config registers, queue pointers and stage valid bits
`default_nettype none
module disk_request_chs_lba_checker #(
  parameter int DRIVE_SLOTS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        push,
  output logic             full,
  input  wire logic [2:0]  func,
  input  wire logic [7:0]  drive_number,
  input  wire logic [9:0]  cylinder_in,
  input  wire logic [7:0]  head_in,
  input  wire logic [7:0]  sector_in,
  input  wire logic [31:0] block_address,
  input  wire logic [7:0]  sector_count,
  output logic             empty,
  input  wire logic        pop,
  output logic             ok,
  output logic [2:0]       error_code,
  output logic [31:0]      lba_out,
  output logic [15:0]      cylinder_out,
  output logic [7:0]       head_out,
  output logic [7:0]       sector_out,
  output logic             beyond_image
);

  drck_pkg::cfg_t cfg;
  drck_pkg::req_t req_in;
  drck_pkg::req_t req_q;
  drck_pkg::res_t res;
  logic q_empty;
  logic q_pop;
  logic [2:0] reg_index;

  assign pready = 1'b1;
  assign reg_index = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.heads <= 8'd1;
      cfg.sectors <= 8'd1;
      cfg.image <= 23'd0;
      cfg.present <= 1'b0;
      cfg.protect <= 1'b0;
      cfg.slot <= 2'd0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_index)
        drck_pkg::R_HEADS:   cfg.heads <= pwdata[7:0];
        drck_pkg::R_SECTORS: cfg.sectors <= pwdata[7:0];
        drck_pkg::R_IMAGE:   cfg.image <= pwdata[22:0];
        drck_pkg::R_MEDIUM:  cfg.present <= pwdata[0];
        drck_pkg::R_PROTECT: cfg.protect <= pwdata[0];
        drck_pkg::R_SLOT:    cfg.slot <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      drck_pkg::R_HEADS:   prdata = {24'd0, cfg.heads};
      drck_pkg::R_SECTORS: prdata = {24'd0, cfg.sectors};
      drck_pkg::R_IMAGE:   prdata = {9'd0, cfg.image};
      drck_pkg::R_MEDIUM:  prdata = {31'd0, cfg.present};
      drck_pkg::R_PROTECT: prdata = {31'd0, cfg.protect};
      drck_pkg::R_SLOT:    prdata = {30'd0, cfg.slot};
      default:             prdata = 32'd0;
    endcase
  end

  drck_front #(.DRIVE_SLOTS(DRIVE_SLOTS)) u_front (
    .cfg(cfg), .func(func), .drive_number(drive_number), .cylinder_in(cylinder_in),
    .head_in(head_in), .sector_in(sector_in), .block_address(block_address),
    .sector_count(sector_count), .req(req_in)
  );

  drck_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push), .wdata(req_in), .full(full),
    .pop(q_pop), .rdata(req_q), .empty(q_empty)
  );

  drck_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .req_valid(!q_empty), .req(req_q),
    .req_take(q_pop), .empty(empty), .pop(pop), .res(res)
  );

  assign ok = res.ok;
  assign error_code = res.error_code;
  assign lba_out = res.lba_out;
  assign cylinder_out = res.cylinder_out;
  assign head_out = res.head_out;
  assign sector_out = res.sector_out;
  assign beyond_image = res.beyond_image;

  a_ok_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (ok == (error_code == drck_pkg::E_NONE)))
    else $error("ok and error code disagree");

  a_fail_clear: assert property (@(posedge clk) disable iff (rst)
    (!empty && !ok) |-> (lba_out == 32'd0 && !beyond_image && sector_out == 8'd0))
    else $error("failed request carries payload");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(lba_out) && $stable(error_code)))
    else $error("stalled result changed");

endmodule
`default_nettype wire
